>>> sv/meter_poll_request_sequencer_macros.svh
// assertion helpers for the sequencer top module
`ifndef METER_POLL_REQUEST_SEQUENCER_MACROS_SVH
`define METER_POLL_REQUEST_SEQUENCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MPRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MPRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mprs_pkg.sv
`timescale 1ns / 1ps

package mprs_pkg;

    // sequencer phase
    typedef enum logic [1:0] {
        PH_BATCH  = 2'd0,
        PH_NODE   = 2'd1,
        PH_STATUS = 2'd2,
        PH_CMD    = 2'd3
    } t_phase;

    // request put on the link
    typedef enum logic [2:0] {
        RK_NONE   = 3'd0,
        RK_BATCH  = 3'd1,
        RK_STATUS = 3'd2,
        RK_NODE   = 3'd3,
        RK_CMD    = 3'd4,
        RK_SWITCH = 3'd5
    } t_req_kind;

    // input word kinds
    localparam logic [1:0] ITEM_SLOT = 2'd0;
    localparam logic [1:0] ITEM_RESP = 2'd1;
    localparam logic [1:0] ITEM_TICK = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_INTERVAL = 1'd1;

    localparam logic [9:0]  DEVICE_COUNT_RST   = 10'd10;
    localparam logic [15:0] BATCH_INTERVAL_RST = 16'd43200;

    localparam logic [7:0]  TASK_CODE_SWITCH = 8'd1;
    localparam logic [10:0] LONG_FRAME_LEN   = 11'd40;
    localparam logic [15:0] SECS_MAX         = 16'hFFFF;
    localparam int          LINK_MOD         = 1000;

    // frame tag characters
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_U = 8'h55;
    localparam logic [7:0] CH_Y = 8'h59;

    typedef struct packed {
        logic [1:0]  kind;
        logic        task_present;
        logic        task_is_control;
        logic [7:0]  task_code;
        logic [9:0]  task_addr;
        logic        task_on;
        logic [10:0] resp_len;
        logic [7:0]  resp_byte0;
        logic [7:0]  resp_byte1;
        logic [7:0]  resp_byte2;
        logic [7:0]  resp_byte3;
    } t_item;

    typedef struct packed {
        t_req_kind  req_kind;
        logic [9:0] req_addr;
        logic [9:0] req_node_start;
        logic       req_switch_on;
        logic       task_done;
        logic       net_free;
    } t_result;

    typedef struct packed {
        logic [9:0]  device_count;
        logic [15:0] batch_interval;
    } t_cfg;

    // three-digit address, one compare and subtract
    function automatic logic [9:0] mod_link_addr(input logic [9:0] a);
        logic [9:0] r;
        r = a;
        if (a >= 10'(LINK_MOD)) begin
            r = a - 10'(LINK_MOD);
        end
        return r;
    endfunction

endpackage

>>> sv/mprs_item_if.sv
`timescale 1ns / 1ps

interface mprs_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        task_present;
    logic        task_is_control;
    logic [7:0]  task_code;
    logic [9:0]  task_addr;
    logic        task_on;
    logic [10:0] resp_len;
    logic [7:0]  resp_byte0;
    logic [7:0]  resp_byte1;
    logic [7:0]  resp_byte2;
    logic [7:0]  resp_byte3;

    modport source (
        output valid, kind, task_present, task_is_control, task_code, task_addr, task_on,
        output resp_len, resp_byte0, resp_byte1, resp_byte2, resp_byte3,
        input  ready
    );
    modport sink (
        input  valid, kind, task_present, task_is_control, task_code, task_addr, task_on,
        input  resp_len, resp_byte0, resp_byte1, resp_byte2, resp_byte3,
        output ready
    );
endinterface

>>> sv/mprs_result_if.sv
`timescale 1ns / 1ps

interface mprs_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_kind;
    logic [9:0] req_addr;
    logic [9:0] req_node_start;
    logic       req_switch_on;
    logic       task_done;
    logic       net_free;

    modport source (
        output valid, req_kind, req_addr, req_node_start, req_switch_on, task_done, net_free,
        input  ready
    );
    modport sink (
        input  valid, req_kind, req_addr, req_node_start, req_switch_on, task_done, net_free,
        output ready
    );
endinterface

>>> sv/mprs_cfg_if.sv
`timescale 1ns / 1ps

interface mprs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mprs_pkg::CFG_IDX_W-1:0] index;
    logic [15:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/mprs_cfg_regs.sv
`timescale 1ns / 1ps

module mprs_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mprs_cfg_if.sink       i_cfg,
    output mprs_pkg::t_cfg o_cfg
);

    mprs_pkg::t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_count   <= mprs_pkg::DEVICE_COUNT_RST;
            r_cfg.batch_interval <= mprs_pkg::BATCH_INTERVAL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mprs_pkg::CFG_DEVICE_COUNT:   r_cfg.device_count   <= i_cfg.data[9:0];
                mprs_pkg::CFG_BATCH_INTERVAL: r_cfg.batch_interval <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

>>> sv/mprs_seq_core.sv
`timescale 1ns / 1ps

module mprs_seq_core #(
    parameter int NODES_PER_GROUP = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  mprs_pkg::t_item   i_item,
    input  mprs_pkg::t_cfg    i_cfg,
    output mprs_pkg::t_result o_result
);

    // width that holds NODES_PER_GROUP * 128 and the link modulus
    localparam int LIN_RAW = $clog2(NODES_PER_GROUP * 128 + 1);
    localparam int LIN_W   = (LIN_RAW > 10) ? LIN_RAW : 10;
    localparam int MOD_STEPS = (NODES_PER_GROUP * 127 + 1) / mprs_pkg::LINK_MOD;

    mprs_pkg::t_phase r_phase, n_phase;
    logic [6:0]  r_group_index, n_group_index;
    logic        r_net_free, n_net_free;
    logic        r_batch_started, n_batch_started;
    logic        r_cmd_pending, n_cmd_pending;
    logic        r_task_in_flight, n_task_in_flight;
    logic [9:0]  r_ctrl_addr, n_ctrl_addr;
    logic [15:0] r_secs, n_secs;

    logic             switch_ok;
    logic             batch_due;
    logic             group_wrap;
    logic [LIN_W-1:0] wrap_prod;
    logic [LIN_W-1:0] node_lin;
    logic             resp_ok, resp_ans, resp_free, resp_busy, resp_long;

    // decode helpers
    assign switch_ok = i_item.task_is_control && r_net_free
                       && (i_item.task_code == mprs_pkg::TASK_CODE_SWITCH);
    assign batch_due = r_secs > i_cfg.batch_interval;
    assign resp_ok   = (i_item.resp_byte0 == mprs_pkg::CH_O)
                       && (i_item.resp_byte1 == mprs_pkg::CH_K);
    assign resp_ans  = (i_item.resp_byte0 == mprs_pkg::CH_A)
                       && (i_item.resp_byte1 == mprs_pkg::CH_N)
                       && (i_item.resp_byte2 == mprs_pkg::CH_S);
    assign resp_free = (i_item.resp_byte0 == mprs_pkg::CH_F)
                       && (i_item.resp_byte1 == mprs_pkg::CH_R)
                       && (i_item.resp_byte2 == mprs_pkg::CH_E)
                       && (i_item.resp_byte3 == mprs_pkg::CH_E);
    assign resp_busy = (i_item.resp_byte0 == mprs_pkg::CH_B)
                       && (i_item.resp_byte1 == mprs_pkg::CH_U)
                       && (i_item.resp_byte2 == mprs_pkg::CH_S)
                       && (i_item.resp_byte3 == mprs_pkg::CH_Y);
    assign resp_long = i_item.resp_len >= mprs_pkg::LONG_FRAME_LEN;

    // last group reached: nodes covered so far reach the device count, or the group index is at its maximum
    assign wrap_prod  = LIN_W'(NODES_PER_GROUP) * (LIN_W'(r_group_index) + LIN_W'(1));
    assign group_wrap = (r_group_index == 7'h7F) || (wrap_prod >= LIN_W'(i_cfg.device_count));

    // first node of the current group, three decimal digits
    always_comb begin
        node_lin = LIN_W'(NODES_PER_GROUP) * LIN_W'(r_group_index) + LIN_W'(1);
        for (int s = 0; s < MOD_STEPS; s++) begin
            if (node_lin >= LIN_W'(mprs_pkg::LINK_MOD)) begin
                node_lin = node_lin - LIN_W'(mprs_pkg::LINK_MOD);
            end
        end
    end

    // next state
    always_comb begin
        n_phase          = r_phase;
        n_group_index    = r_group_index;
        n_net_free       = r_net_free;
        n_batch_started  = r_batch_started;
        n_cmd_pending    = r_cmd_pending;
        n_task_in_flight = r_task_in_flight;
        n_ctrl_addr      = r_ctrl_addr;
        n_secs           = r_secs;
        if (i_fire) begin
            unique case (i_item.kind)
                mprs_pkg::ITEM_SLOT: begin
                    n_task_in_flight = 1'b0;
                    if (i_item.task_present) begin
                        if (switch_ok) begin
                            n_ctrl_addr = i_item.task_addr;
                        end
                        n_task_in_flight = 1'b1;
                    end else if (!r_batch_started) begin
                        n_secs  = '0;
                        n_phase = mprs_pkg::PH_STATUS;
                    end else begin
                        unique case (r_phase)
                            mprs_pkg::PH_BATCH: begin
                                if (batch_due) begin
                                    n_secs  = '0;
                                    n_phase = mprs_pkg::PH_STATUS;
                                end
                            end
                            mprs_pkg::PH_NODE: begin
                                if (group_wrap) begin
                                    n_phase       = mprs_pkg::PH_BATCH;
                                    n_group_index = '0;
                                end else begin
                                    n_group_index = r_group_index + 7'd1;
                                end
                            end
                            mprs_pkg::PH_CMD: begin
                                n_cmd_pending = 1'b0;
                                n_phase       = mprs_pkg::PH_STATUS;
                            end
                            default: ;
                        endcase
                    end
                end
                mprs_pkg::ITEM_RESP: begin
                    priority if (r_task_in_flight) begin
                        if (resp_ok) begin
                            n_cmd_pending = 1'b1;
                            n_phase       = mprs_pkg::PH_STATUS;
                        end
                    end else if (resp_long || resp_ans) begin
                        // payload frames are decoded elsewhere
                    end else if (resp_free) begin
                        n_phase    = r_cmd_pending ? mprs_pkg::PH_CMD : mprs_pkg::PH_NODE;
                        n_net_free = 1'b1;
                    end else if (resp_busy) begin
                        n_phase    = mprs_pkg::PH_STATUS;
                        n_net_free = 1'b0;
                    end else begin
                        n_batch_started = 1'b1;
                    end
                end
                mprs_pkg::ITEM_TICK: begin
                    if (r_secs != mprs_pkg::SECS_MAX) begin
                        n_secs = r_secs + 16'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // result word
    always_comb begin
        o_result                = '0;
        o_result.req_kind       = mprs_pkg::RK_NONE;
        o_result.net_free       = n_net_free;
        unique case (i_item.kind)
            mprs_pkg::ITEM_SLOT: begin
                if (i_item.task_present) begin
                    if (switch_ok) begin
                        o_result.req_kind      = mprs_pkg::RK_SWITCH;
                        o_result.req_addr      = mprs_pkg::mod_link_addr(i_item.task_addr);
                        o_result.req_switch_on = i_item.task_on;
                    end
                end else if (!r_batch_started) begin
                    o_result.req_kind = mprs_pkg::RK_BATCH;
                end else begin
                    unique case (r_phase)
                        mprs_pkg::PH_BATCH: begin
                            o_result.req_kind = batch_due ? mprs_pkg::RK_BATCH
                                                          : mprs_pkg::RK_STATUS;
                        end
                        mprs_pkg::PH_NODE: begin
                            o_result.req_kind = mprs_pkg::RK_NODE;
                            if (r_group_index != 7'd0) begin
                                o_result.req_node_start = node_lin[9:0];
                            end
                        end
                        mprs_pkg::PH_STATUS: begin
                            o_result.req_kind = mprs_pkg::RK_STATUS;
                        end
                        mprs_pkg::PH_CMD: begin
                            o_result.req_kind = mprs_pkg::RK_CMD;
                            o_result.req_addr = mprs_pkg::mod_link_addr(r_ctrl_addr);
                        end
                        default: ;
                    endcase
                end
            end
            mprs_pkg::ITEM_RESP: begin
                o_result.task_done = r_task_in_flight && resp_ok;
            end
            default: ;
        endcase
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= mprs_pkg::PH_STATUS;
            r_group_index    <= '0;
            r_net_free       <= 1'b0;
            r_batch_started  <= 1'b0;
            r_cmd_pending    <= 1'b0;
            r_task_in_flight <= 1'b0;
            r_ctrl_addr      <= '0;
            r_secs           <= '0;
        end else begin
            r_phase          <= n_phase;
            r_group_index    <= n_group_index;
            r_net_free       <= n_net_free;
            r_batch_started  <= n_batch_started;
            r_cmd_pending    <= n_cmd_pending;
            r_task_in_flight <= n_task_in_flight;
            r_ctrl_addr      <= n_ctrl_addr;
            r_secs           <= n_secs;
        end
    end

endmodule

>>> sv/meter_poll_request_sequencer.sv
`timescale 1ns / 1ps
// Polling request sequencer for the master side of a meter concentrator link.
// i_item takes one word per handshake: a send slot, a classified response
// header or a one-second tick. o_result gives exactly one word per input word,
// in order: the request to send (or none), task completion and network status.
// i_cfg writes device_count (index 0) and batch_interval (index 1); it is
// always ready. It must be written by the user only while no word is in
// flight; the block itself does not enforce this. An accepted word passes
// from the input register through the decision logic into the result register.
// Throughput: one word per cycle while o_result is ready; the decision logic
// is a single pass over the sequencer state, so words follow back to back.
// When o_result stalls, the result register and the input register hold their
// words and i_item.ready drops once both are full; nothing is lost.
// Reset (synchronous, active low) empties both registers, puts the sequencer in
// the status poll phase with the network busy and the timer at zero, and loads
// the register defaults (10 meters, 43200 s between batch readings).
`include "meter_poll_request_sequencer_macros.svh"

module meter_poll_request_sequencer #(
    parameter int NODES_PER_GROUP = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mprs_item_if.sink     i_item,
    mprs_result_if.source o_result,
    mprs_cfg_if.sink      i_cfg
);

    logic              r_s1_valid;
    mprs_pkg::t_item   r_s1, n_s1;
    logic              r_out_valid;
    mprs_pkg::t_result r_out, n_out;
    mprs_pkg::t_cfg    cfg;
    logic              out_take;
    logic              s1_fire;
    logic              in_fire;

    // handshake control
    assign out_take     = !r_out_valid || o_result.ready;
    assign s1_fire      = r_s1_valid && out_take;
    assign i_item.ready = !r_s1_valid || out_take;
    assign in_fire      = i_item.valid && i_item.ready;

    // pack incoming word
    always_comb begin
        n_s1.kind            = i_item.kind;
        n_s1.task_present    = i_item.task_present;
        n_s1.task_is_control = i_item.task_is_control;
        n_s1.task_code       = i_item.task_code;
        n_s1.task_addr       = i_item.task_addr;
        n_s1.task_on         = i_item.task_on;
        n_s1.resp_len        = i_item.resp_len;
        n_s1.resp_byte0      = i_item.resp_byte0;
        n_s1.resp_byte1      = i_item.resp_byte1;
        n_s1.resp_byte2      = i_item.resp_byte2;
        n_s1.resp_byte3      = i_item.resp_byte3;
    end

    mprs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mprs_seq_core #(
        .NODES_PER_GROUP (NODES_PER_GROUP)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_fire),
        .i_item   (r_s1),
        .i_cfg    (cfg),
        .o_result (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.req_kind       = r_out.req_kind;
    assign o_result.req_addr       = r_out.req_addr;
    assign o_result.req_node_start = r_out.req_node_start;
    assign o_result.req_switch_on  = r_out.req_switch_on;
    assign o_result.task_done      = r_out.task_done;
    assign o_result.net_free       = r_out.net_free;

    // checks
    `MPRS_ASSERT_NEXT(a_fire_fills_out, i_clk, i_rst_n, s1_fire, r_out_valid, "result word dropped")
    `MPRS_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !out_take, r_s1_valid && $stable(r_s1), "input word overwritten")
    `MPRS_ASSERT_NOW(a_on_only_switch, i_clk, i_rst_n, r_out_valid && (r_out.req_kind != mprs_pkg::RK_SWITCH), !r_out.req_switch_on, "switch flag on non-switch word")
    `MPRS_ASSERT_NOW(a_start_only_node, i_clk, i_rst_n, r_out_valid && (r_out.req_kind != mprs_pkg::RK_NODE), r_out.req_node_start == 10'd0, "node start on non-read word")

endmodule
